@@ hw/rtl/pim_pkg.sv @@
// Shared types, widths and register indexes of the perspective inverse mapping unit.
`timescale 1ns / 1ps
`default_nettype none
package pim_pkg;

	localparam int COORD_W  = 12;
	localparam int COEF_W   = 48;
	localparam int NUM_COEF = 8;
	localparam int IDX_W    = 3;
	localparam int OUT_W    = 16;
	localparam int STAT_W   = 2;
	localparam int PROD_W   = COEF_W + COORD_W + 1;
	localparam int SUM_W    = 64;
	localparam int MAG_W    = 62;
	localparam int QMAG_W   = 15;
	localparam int QDEPTH   = 4;

	localparam int DEF_SRC_WIDTH  = 4096;
	localparam int DEF_SRC_HEIGHT = 4096;

	localparam logic [IDX_W-1:0] IDX_M00 = 3'd0;
	localparam logic [IDX_W-1:0] IDX_M01 = 3'd1;
	localparam logic [IDX_W-1:0] IDX_M02 = 3'd2;
	localparam logic [IDX_W-1:0] IDX_M10 = 3'd3;
	localparam logic [IDX_W-1:0] IDX_M11 = 3'd4;
	localparam logic [IDX_W-1:0] IDX_M12 = 3'd5;
	localparam logic [IDX_W-1:0] IDX_M20 = 3'd6;
	localparam logic [IDX_W-1:0] IDX_M21 = 3'd7;

	localparam logic [COEF_W-1:0] COEF_ONE  = 48'h0001_0000_0000;
	localparam logic [SUM_W-1:0]  DEN_ONE   = 64'h0000_0001_0000_0000;

	localparam logic [STAT_W-1:0] ST_INSIDE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
	localparam logic [STAT_W-1:0] ST_DENZERO = 2'd2;

	typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_arr_t;

	// Identity homography: m11 and m00 are 1.0, everything else is zero.
	localparam coef_arr_t COEF_RESET = {{(3*COEF_W){1'b0}}, COEF_ONE,
		{(3*COEF_W){1'b0}}, COEF_ONE};

	// One classified item: magnitudes and signs of the two numerators and the denominator.
	typedef struct packed {
		logic             neg_x;
		logic             neg_y;
		logic             den_zero;
		logic [MAG_W-1:0] mag_nx;
		logic [MAG_W-1:0] mag_ny;
		logic [MAG_W-1:0] mag_d;
	} cls_item_t;

	// Queue handshake between front and back.
	typedef struct packed {
		logic push;
		logic pop;
		logic empty;
	} q_ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/perspective_inverse_map_unit.sv @@
// New items are taken while earlier ones are still in flight, as long as queue credit remains;
// the divider back end retires one quotient bit per stage.
// The front end runs three fixed stages and feeds a four-entry queue, credited so it never overflows.
// Reset (arst_n low, asynchronous) clears all valid bits, the queue and the credit counter,
// and loads the identity homography into the coefficient registers.
`timescale 1ns / 1ps
`default_nettype none
module perspective_inverse_map_unit
	import pim_pkg::*;
#(
	parameter int SRC_WIDTH  = DEF_SRC_WIDTH,
	parameter int SRC_HEIGHT = DEF_SRC_HEIGHT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [IDX_W-1:0]     wr_index,
	input  wire logic [COEF_W-1:0]    wr_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [COORD_W-1:0]   dst_x,
	input  wire logic [COORD_W-1:0]   dst_y,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [OUT_W-1:0]   src_x,
	output logic signed [OUT_W-1:0]   src_y,
	output logic [STAT_W-1:0]         status
);

	// Coefficient registers. The reset value is the identity mapping, so an
	// unconfigured block passes coordinates through unchanged.
	coef_arr_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (wr_en) begin
			coef_q[wr_index] <= wr_data;
		end
	end

	// The front end forms the three Q32.32 sums and splits each into sign and
	// magnitude. It never stalls: it only takes an item when the queue is
	// sure to have room once the item reaches it.
	logic      q_push, q_empty, q_full, q_pop;
	cls_item_t q_in, q_head;

	pim_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.dst_x     (dst_x),
		.dst_y     (dst_y),
		.q_pop     (q_pop),
		.push      (q_push),
		.push_item (q_in)
	);

	pim_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.empty     (q_empty),
		.full      (q_full),
		.head      (q_head)
	);

	// The back end divides both numerators by the denominator magnitude,
	// truncating toward zero, and saturates to 16 bits. A downstream stall
	// freezes the whole divider pipe.
	pim_back #(
		.SRC_WIDTH  (SRC_WIDTH),
		.SRC_HEIGHT (SRC_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.src_x     (src_x),
		.src_y     (src_y),
		.status    (status)
	);

	q_ctrl_t qc;
	assign qc = '{push: q_push, pop: q_pop, empty: q_empty};

	// The credit scheme must keep the queue from ever taking an item while full, unless one is popped at the same time.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !(qc.push && !qc.pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		qc.empty |-> !qc.pop)
		else $error("queue read while empty");

	a_denzero_coords: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_DENZERO) |-> (src_x == '0 && src_y == '0))
		else $error("zero denominator with nonzero coordinates");

	a_neg_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (src_x[OUT_W-1] || src_y[OUT_W-1])) |-> (status == ST_OUTSIDE))
		else $error("negative source coordinate not flagged outside");

endmodule
`default_nettype wire

@@ hw/rtl/pim_front.sv @@
// Front end: input handshake, coefficient products, sums and sign/magnitude classification.
`timescale 1ns / 1ps
`default_nettype none
module pim_front
	import pim_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire coef_arr_t           coef,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [COORD_W-1:0]  dst_x,
	input  wire logic [COORD_W-1:0]  dst_y,
	input  wire logic                q_pop,
	output logic                     push,
	output cls_item_t                push_item
);

	localparam int CNT_W = $clog2(QDEPTH + 1);

	logic [CNT_W-1:0] credit_q;
	logic             acc;
	logic             v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0] p00_s1, p01_s1, p10_s1, p11_s1, p20_s1, p21_s1;
	logic signed [COEF_W-1:0] m02_s1, m12_s1;
	logic signed [SUM_W-1:0]  nx_s2, ny_s2, d_s2;
	cls_item_t                item_s3;
	logic signed [COORD_W:0]  xs, ys;

	// Items in flight in this front end plus the queue never exceed the queue depth.
	assign in_ready = (credit_q < CNT_W'(QDEPTH));
	assign acc      = in_valid && in_ready;
	assign xs       = $signed({1'b0, dst_x});
	assign ys       = $signed({1'b0, dst_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			credit_q <= credit_q + CNT_W'(acc) - CNT_W'(q_pop);
			v_s1     <= acc;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p00_s1 <= $signed(coef[IDX_M00]) * xs;
		p01_s1 <= $signed(coef[IDX_M01]) * ys;
		p10_s1 <= $signed(coef[IDX_M10]) * xs;
		p11_s1 <= $signed(coef[IDX_M11]) * ys;
		p20_s1 <= $signed(coef[IDX_M20]) * xs;
		p21_s1 <= $signed(coef[IDX_M21]) * ys;
		m02_s1 <= $signed(coef[IDX_M02]);
		m12_s1 <= $signed(coef[IDX_M12]);

		nx_s2 <= SUM_W'(p00_s1) + SUM_W'(p01_s1) + SUM_W'(m02_s1);
		ny_s2 <= SUM_W'(p10_s1) + SUM_W'(p11_s1) + SUM_W'(m12_s1);
		d_s2  <= SUM_W'(p20_s1) + SUM_W'(p21_s1) + $signed(DEN_ONE);

		// The quotient sign folds the denominator sign in here.
		item_s3.neg_x    <= nx_s2[SUM_W-1] ^ d_s2[SUM_W-1];
		item_s3.neg_y    <= ny_s2[SUM_W-1] ^ d_s2[SUM_W-1];
		item_s3.den_zero <= (d_s2 == '0);
		item_s3.mag_nx   <= MAG_W'(nx_s2[SUM_W-1] ? -nx_s2 : nx_s2);
		item_s3.mag_ny   <= MAG_W'(ny_s2[SUM_W-1] ? -ny_s2 : ny_s2);
		item_s3.mag_d    <= MAG_W'(d_s2[SUM_W-1] ? -d_s2 : d_s2);
	end

	assign push      = v_s3;
	assign push_item = item_s3;

endmodule
`default_nettype wire

@@ hw/rtl/pim_queue.sv @@
// Small FIFO that decouples the front end from the divider back end.
`timescale 1ns / 1ps
`default_nettype none
module pim_queue
	import pim_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire cls_item_t push_item,
	input  wire logic      pop,
	output logic           empty,
	output logic           full,
	output cls_item_t      head
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cls_item_t        mem_q [QDEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(QDEPTH));
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

endmodule
`default_nettype wire

@@ hw/rtl/pim_back.sv @@
// Back end: pipelined restoring divider, one quotient bit per stage, then saturation and status.
`timescale 1ns / 1ps
`default_nettype none
module pim_back
	import pim_pkg::*;
#(
	parameter int SRC_WIDTH  = DEF_SRC_WIDTH,
	parameter int SRC_HEIGHT = DEF_SRC_HEIGHT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire cls_item_t        head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic signed [OUT_W-1:0] src_x,
	output logic signed [OUT_W-1:0] src_y,
	output logic [STAT_W-1:0]     status
);

	localparam int WIDE_W = MAG_W + QMAG_W;

	typedef struct packed {
		logic              neg_x;
		logic              neg_y;
		logic              den_zero;
		logic              ovf_x;
		logic              ovf_y;
		logic [MAG_W-1:0]  d;
		logic [MAG_W-1:0]  rem_x;
		logic [MAG_W-1:0]  rem_y;
		logic [QMAG_W-1:0] qx;
		logic [QMAG_W-1:0] qy;
	} div_t;

	logic  en;
	logic  v_s [QMAG_W+1];
	div_t  div_s [QMAG_W+1];
	logic [WIDE_W-1:0] lim;

	// The whole back end advances unless the output holds an item that is not taken.
	assign en  = !out_valid || out_ready;
	assign pop = en && !q_empty;
	assign lim = {head.mag_d, {QMAG_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= !q_empty;
		end
	end

	// Entry stage: a quotient of 2^15 or more saturates.
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].neg_x    <= head.neg_x;
			div_s[0].neg_y    <= head.neg_y;
			div_s[0].den_zero <= head.den_zero;
			div_s[0].ovf_x    <= (WIDE_W'(head.mag_nx) >= lim);
			div_s[0].ovf_y    <= (WIDE_W'(head.mag_ny) >= lim);
			div_s[0].d        <= head.mag_d;
			div_s[0].rem_x    <= head.mag_nx;
			div_s[0].rem_y    <= head.mag_ny;
			div_s[0].qx       <= '0;
			div_s[0].qy       <= '0;
		end
	end

	for (genvar k = 1; k <= QMAG_W; k++) begin : g_div
		localparam int B = QMAG_W - k;
		logic [WIDE_W-1:0] dsh;
		logic              gx, gy;
		div_t              nxt;

		assign dsh = WIDE_W'(div_s[k-1].d) << B;
		assign gx  = (WIDE_W'(div_s[k-1].rem_x) >= dsh);
		assign gy  = (WIDE_W'(div_s[k-1].rem_y) >= dsh);

		always_comb begin
			nxt = div_s[k-1];
			if (gx) nxt.rem_x = MAG_W'(WIDE_W'(div_s[k-1].rem_x) - dsh);
			if (gy) nxt.rem_y = MAG_W'(WIDE_W'(div_s[k-1].rem_y) - dsh);
			nxt.qx = div_s[k-1].qx | (QMAG_W'(gx) << B);
			nxt.qy = div_s[k-1].qy | (QMAG_W'(gy) << B);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= nxt;
			end
		end
	end

	div_t              fin;
	logic              out_x, out_y;
	logic signed [OUT_W-1:0] fx, fy;

	assign fin = div_s[QMAG_W];

	always_comb begin
		out_x = fin.ovf_x || (fin.neg_x && fin.qx != '0) ||
		        (!fin.neg_x && 32'(fin.qx) >= 32'(SRC_WIDTH));
		out_y = fin.ovf_y || (fin.neg_y && fin.qy != '0) ||
		        (!fin.neg_y && 32'(fin.qy) >= 32'(SRC_HEIGHT));
		if (fin.ovf_x) fx = fin.neg_x ? 16'sh8000 : 16'sh7fff;
		else           fx = fin.neg_x ? -$signed({1'b0, fin.qx}) : $signed({1'b0, fin.qx});
		if (fin.ovf_y) fy = fin.neg_y ? 16'sh8000 : 16'sh7fff;
		else           fy = fin.neg_y ? -$signed({1'b0, fin.qy}) : $signed({1'b0, fin.qy});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[QMAG_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fin.den_zero) begin
				src_x  <= '0;
				src_y  <= '0;
				status <= ST_DENZERO;
			end else begin
				src_x  <= fx;
				src_y  <= fy;
				status <= (out_x || out_y) ? ST_OUTSIDE : ST_INSIDE;
			end
		end
	end

endmodule
`default_nettype wire
